[hdl/swmm_pkg.sv]
// Shared constants and types of the sliding window min/max filter.
`default_nettype none
package swmm_pkg;

  localparam int SWMM_MAX_WINDOW  = 63;
  localparam int SWMM_SAMPLE_BITS = 16;
  localparam int SWMM_RESET_WINDOW = 5;
  localparam int SWMM_KSIZE_BITS  = 6;
  localparam int SWMM_CFG_INDEX_BITS = 4;
  localparam int SWMM_CFG_DATA_BITS  = 8;

  typedef enum logic [SWMM_CFG_INDEX_BITS-1:0] {
    REG_WINDOW_SIZE = 4'd0,
    REG_MODE        = 4'd1
  } swmm_reg_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } swmm_state_t;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic en;     // update the cells this cycle
    logic shift;  // drop the front pair, every cell takes its right neighbor
    logic ins;    // insert the new sample and pop dominated pairs
    logic inc;    // age every pair by one position
    logic clear;  // start of a line, treat every cell as empty
    logic mode;   // 1 keeps the maximum, 0 the minimum
  } swmm_ctrl_t;

endpackage
`default_nettype wire

[hdl/swmm_channels.sv]
// Stream and configuration channel interfaces of the sliding window min/max filter.
`default_nettype none
interface swmm_sample_if import swmm_pkg::*; #(
  parameter int SAMPLE_BITS = SWMM_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_in_line;

  modport source (output valid, output sample, output last_in_line, input ready);
  modport sink (input valid, input sample, input last_in_line, output ready);
endinterface

interface swmm_result_if import swmm_pkg::*; #(
  parameter int SAMPLE_BITS = SWMM_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          end_of_line;
  logic                          last_of_run;

  modport source (output valid, output filtered, output end_of_line, output last_of_run,
                  input ready);
  modport sink (input valid, input filtered, input end_of_line, input last_of_run,
                output ready);
endinterface

interface swmm_cfg_if import swmm_pkg::*;;
  logic                           valid;
  logic                           ready;
  logic [SWMM_CFG_INDEX_BITS-1:0] index;
  logic [SWMM_CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/sliding_window_min_max_filter.sv]
// Top level of the sliding window min/max filter for one line of samples at a time.
//
// Samples enter on the samples channel, one beat each, the final sample of a line
// carrying last_in_line. Results leave on the results channel. With K the window
// size and H = K/2, the result for position x is the minimum (mode 0) or maximum
// (mode 1) over positions x+H-K+1 .. x+H, clipped to the line.
// Inside a line the block takes one sample per cycle: the cell chain updates with each
// accepted sample, and a result is in the output register in the cycle after the sample
// at x+H was accepted. The first H samples of a line give no result.
// The final sample starts a flush that gives H+1 results (fewer on a line shorter
// than that), one per cycle from the output register; no sample is taken meanwhile.
// The last result of the line carries end_of_line and last_of_run.
// window_size and mode are written on the cfg channel and sampled at the first
// sample of each line. Reset sets window_size to 5, mode to minimum, no line open.
// A stalled receiver holds the output register; the block then takes a new sample
// only in the cycle the held result is taken.
`default_nettype none
module sliding_window_min_max_filter import swmm_pkg::*; #(
  parameter int MAX_WINDOW  = SWMM_MAX_WINDOW
) (
  input  wire           clk,
  input  wire           rst,
  swmm_sample_if.sink   samples,
  swmm_result_if.source results,
  swmm_cfg_if.sink      cfg
);

  localparam int KW = $clog2(MAX_WINDOW + 1);
  localparam int HW = (KW > 1) ? KW - 1 : 1;
  localparam int CW = (KW > SWMM_KSIZE_BITS) ? KW : SWMM_KSIZE_BITS;

  swmm_state_t state, state_next;

  logic [SWMM_KSIZE_BITS-1:0] reg_ksize;
  logic                       reg_mode;
  logic                       line_open;
  logic [KW-1:0]              line_k;
  logic                       line_mode;
  logic                       lead_done;
  logic [HW-1:0]              pcount;
  logic [HW-1:0]              dcnt;
  logic                       out_valid;

  logic [CW-1:0]   kz;
  logic [KW-1:0]   cur_k;
  logic [HW-1:0]   cur_h;
  logic            cur_mode;
  logic [HW-1:0]   cur_pcount;
  logic            lead_now;
  logic [KW-1:0]   flush_limit;
  logic            out_free;
  logic            in_ready;
  logic            flush_go;
  logic            in_fire;
  logic            out_load;
  swmm_ctrl_t      ctrl;

  logic                               front_valid;
  logic [KW-1:0]                      front_age;
  logic signed [SWMM_SAMPLE_BITS-1:0] front_value_next;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_ksize <= SWMM_KSIZE_BITS'(SWMM_RESET_WINDOW);
      reg_mode  <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_WINDOW_SIZE) begin
        reg_ksize <= cfg.data[SWMM_KSIZE_BITS-1:0];
      end else if (cfg.index == REG_MODE) begin
        reg_mode <= cfg.data[0];
      end
    end
  end

  // Window size of the line, clamped into 1 .. MAX_WINDOW.
  always_comb begin
    kz = CW'(reg_ksize);
    if (!line_open) begin
      if (kz == '0) begin
        cur_k = KW'(1);
      end else if (kz > CW'(MAX_WINDOW)) begin
        cur_k = KW'(MAX_WINDOW);
      end else begin
        cur_k = kz[KW-1:0];
      end
    end else begin
      cur_k = line_k;
    end
    cur_h       = HW'(cur_k >> 1);
    cur_mode    = line_open ? line_mode : reg_mode;
    cur_pcount  = line_open ? pcount : '0;
    lead_now    = (line_open & lead_done) | (cur_pcount >= cur_h);
    flush_limit = cur_k - KW'(1) - KW'(cur_h) + KW'(dcnt);
  end

  assign out_free = ~out_valid | results.ready;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (in_fire && samples.last_in_line) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go && dcnt == '0) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    flush_go = 1'b0;
    unique case (state)
      ST_RUN:   in_ready = out_free;
      ST_FLUSH: flush_go = out_free;
      default: begin
        in_ready = 1'b0;
        flush_go = 1'b0;
      end
    endcase
  end

  assign samples.ready = in_ready;
  assign in_fire = samples.valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Chain control: an accepted sample ages, drops and inserts; a flush step only drops.
  always_comb begin
    ctrl.en    = in_fire | flush_go;
    ctrl.ins   = in_fire;
    ctrl.inc   = in_fire;
    ctrl.clear = in_fire & ~line_open;
    ctrl.mode  = cur_mode;
    if (in_fire) begin
      ctrl.shift = line_open & front_valid & (front_age >= cur_k - KW'(1));
    end else begin
      ctrl.shift = front_valid & (front_age > flush_limit);
    end
  end

  swmm_chain #(
    .MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SWMM_SAMPLE_BITS), .AGE_BITS(KW)
  ) u_chain (
    .clk, .rst, .ctrl,
    .new_value(samples.sample),
    .front_valid, .front_age, .front_value_next
  );

  // Line bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_open <= 1'b0;
      lead_done <= 1'b0;
    end else if (in_fire) begin
      line_open <= 1'b1;
      lead_done <= lead_now;
    end else if (flush_go && dcnt == '0) begin
      line_open <= 1'b0;
      lead_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_k    <= cur_k;
      line_mode <= cur_mode;
      pcount    <= lead_now ? cur_pcount : cur_pcount + HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && samples.last_in_line) begin
      dcnt <= lead_now ? cur_h : cur_pcount;
    end else if (flush_go && dcnt != '0) begin
      dcnt <= dcnt - HW'(1);
    end
  end

  // Output register.
  assign out_load = (in_fire & ~samples.last_in_line & lead_now) | flush_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.filtered    <= front_value_next;
      results.end_of_line <= flush_go & (dcnt == '0);
      results.last_of_run <= ~flush_go | (dcnt == '0);
    end
  end

  assign results.valid = out_valid;

  // The newest sample always survives its own insertion.
  a_front_after_insert: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> front_valid)
    else $error("front cell empty after a sample was inserted");

  // Pairs older than the window never sit at the front between samples.
  a_front_age: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && line_open && front_valid) |-> (front_age <= cur_k - KW'(1)))
    else $error("front pair older than the window");

  // The flush count never exceeds half the window.
  a_flush_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (dcnt <= cur_h && line_open))
    else $error("flush count out of range");

  // A result closing a line is always the last of its run.
  a_eol_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && results.end_of_line) |-> results.last_of_run)
    else $error("end of line without last of run");

endmodule
`default_nettype wire

[hdl/swmm_cell.sv]
// One cell of the monotonic window chain: holds a value and its age.
`default_nettype none
module swmm_cell import swmm_pkg::*; #(
  parameter int SAMPLE_BITS = SWMM_SAMPLE_BITS,
  parameter int AGE_BITS    = 6
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire swmm_ctrl_t               ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] new_value,
  input  wire                           right_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] right_value,
  input  wire logic [AGE_BITS-1:0]      right_age,
  input  wire                           left_kept,
  output logic                          valid,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [AGE_BITS-1:0]           age,
  output logic                          kept,
  output logic signed [SAMPLE_BITS-1:0] value_next
);

  logic                          b_valid;
  logic signed [SAMPLE_BITS-1:0] b_value;
  logic [AGE_BITS-1:0]           b_age;
  logic                          dominated;
  logic                          here;
  logic                          valid_next;
  logic [AGE_BITS-1:0]           age_next;

  always_comb begin
    b_valid = ctrl.clear ? 1'b0 : (ctrl.shift ? right_valid : valid);
    b_value = ctrl.shift ? right_value : value;
    b_age   = ctrl.shift ? right_age : age;
    // Equal values count as dominated, so the newer pair replaces the older.
    dominated = ctrl.mode ? (b_value <= new_value) : (b_value >= new_value);
    kept = b_valid & ~(ctrl.ins & dominated);
    // The new pair lands just behind the last pair that survives.
    here = ctrl.ins & ~kept & left_kept;
    valid_next = here | kept;
    value_next = here ? new_value : b_value;
    if (here) begin
      age_next = '0;
    end else if (ctrl.inc) begin
      age_next = b_age + AGE_BITS'(1);
    end else begin
      age_next = b_age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.en) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule
`default_nettype wire

[hdl/swmm_chain.sv]
// Row of window cells; the front cell holds the current minimum or maximum.
`default_nettype none
module swmm_chain import swmm_pkg::*; #(
  parameter int MAX_WINDOW  = SWMM_MAX_WINDOW,
  parameter int SAMPLE_BITS = SWMM_SAMPLE_BITS,
  parameter int AGE_BITS    = 6
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire swmm_ctrl_t               ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] new_value,
  output logic                          front_valid,
  output logic [AGE_BITS-1:0]           front_age,
  output logic signed [SAMPLE_BITS-1:0] front_value_next
);

  logic                          cv    [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cval  [MAX_WINDOW];
  logic [AGE_BITS-1:0]           cage  [MAX_WINDOW];
  logic                          ck    [MAX_WINDOW];
  logic                          rv    [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rval  [MAX_WINDOW];
  logic [AGE_BITS-1:0]           rage  [MAX_WINDOW];
  logic                          lk    [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cnext [MAX_WINDOW];

  genvar i;
  generate
    for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
      if (i == MAX_WINDOW - 1) begin : g_tail
        assign rv[i]   = 1'b0;
        assign rval[i] = '0;
        assign rage[i] = '0;
      end else begin : g_mid
        assign rv[i]   = cv[i+1];
        assign rval[i] = cval[i+1];
        assign rage[i] = cage[i+1];
      end
      if (i == 0) begin : g_head
        assign lk[i] = 1'b1;
        swmm_cell #(.SAMPLE_BITS(SAMPLE_BITS), .AGE_BITS(AGE_BITS)) u_cell (
          .clk, .rst, .ctrl, .new_value,
          .right_valid(rv[i]), .right_value(rval[i]), .right_age(rage[i]),
          .left_kept(lk[i]),
          .valid(cv[i]), .value(cval[i]), .age(cage[i]), .kept(ck[i]),
          .value_next(cnext[i])
        );
      end else begin : g_body
        assign lk[i] = ck[i-1];
        swmm_cell #(.SAMPLE_BITS(SAMPLE_BITS), .AGE_BITS(AGE_BITS)) u_cell (
          .clk, .rst, .ctrl, .new_value,
          .right_valid(rv[i]), .right_value(rval[i]), .right_age(rage[i]),
          .left_kept(lk[i]),
          .valid(cv[i]), .value(cval[i]), .age(cage[i]), .kept(ck[i]),
          .value_next(cnext[i])
        );
      end
    end
  endgenerate

  assign front_valid      = cv[0];
  assign front_age        = cage[0];
  assign front_value_next = cnext[0];

endmodule
`default_nettype wire
